[hw/rtl/pdd_pkg.sv]
// shared types, constants and bcd helper functions for the pressure digit block
package pdd_pkg;

    // raw sample and decimal word sizes
    localparam int SAMPLE_W = 24;
    localparam int BYTE_W   = 8;
    localparam int NIB_W    = 4;
    localparam int NIB_N    = 8;
    localparam int BCD_W    = NIB_W * NIB_N;
    localparam int STAGE_N  = SAMPLE_W / BYTE_W;
    localparam int POS_W    = 4;

    localparam logic [NIB_W-1:0] NIB_ADJ_MIN = 4'd5;
    localparam logic [NIB_W-1:0] NIB_ADJ     = 4'd3;
    localparam logic [NIB_W-1:0] NIB_MAX     = 4'd9;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [BCD_W-1:0]    bcd_t;

    // one incoming sample, most significant byte first
    typedef struct packed {
        logic [BYTE_W-1:0] sample_high;
        logic [BYTE_W-1:0] sample_mid;
        logic [BYTE_W-1:0] sample_low;
    } in_item_t;

    // one display write
    typedef struct packed {
        logic [POS_W-1:0] digit_position;
        logic [NIB_W-1:0] digit_value;
        logic             last_digit;
    } out_item_t;

    // eight shift-add-3 steps, one per input bit, msb first
    function automatic bcd_t dd_step8(input bcd_t bcd_in, input logic [BYTE_W-1:0] chunk);
        bcd_t b;
        b = bcd_in;
        for (int i = 0; i < BYTE_W; i++)
        begin
            for (int n = 0; n < NIB_N; n++)
            begin
                if (b[n*NIB_W +: NIB_W] >= NIB_ADJ_MIN)
                begin
                    b[n*NIB_W +: NIB_W] = b[n*NIB_W +: NIB_W] + NIB_ADJ;
                end
            end
            b = {b[BCD_W-2:0], chunk[BYTE_W-1-i]};
        end
        return b;
    endfunction

    // every nibble holds a decimal digit
    function automatic logic bcd_ok(input bcd_t b);
        logic ok;
        ok = 1'b1;
        for (int n = 0; n < NIB_N; n++)
        begin
            if (b[n*NIB_W +: NIB_W] > NIB_MAX)
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

[hw/rtl/pdd_bcd_pipe.sv]
// three-stage binary to bcd pipeline, one byte of the value per stage
module pdd_bcd_pipe
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  pdd_pkg::sample_t in_value,
    output logic           out_valid,
    input  logic           out_ready,
    output pdd_pkg::bcd_t  out_bcd
);

    localparam int STAGE_N  = pdd_pkg::STAGE_N;
    localparam int SAMPLE_W = pdd_pkg::SAMPLE_W;
    localparam int BYTE_W   = pdd_pkg::BYTE_W;

    logic              valid_reg [STAGE_N];
    pdd_pkg::bcd_t     bcd_reg   [STAGE_N];
    pdd_pkg::sample_t  rest_reg  [STAGE_N];

    logic              src_valid [STAGE_N];
    pdd_pkg::bcd_t     src_bcd   [STAGE_N];
    pdd_pkg::sample_t  src_rest  [STAGE_N];
    pdd_pkg::bcd_t     bcd_next  [STAGE_N];
    pdd_pkg::sample_t  rest_next [STAGE_N];
    logic [STAGE_N:0]  stage_ready;

    // per-stage sources and ready chain
    always_comb
    begin
        stage_ready[STAGE_N] = out_ready;
        for (int j = STAGE_N - 1; j >= 0; j--)
        begin
            stage_ready[j] = !valid_reg[j] || stage_ready[j+1];
        end
        for (int j = 0; j < STAGE_N; j++)
        begin
            if (j == 0)
            begin
                src_valid[j] = in_valid;
                src_bcd[j]   = '0;
                src_rest[j]  = in_value;
            end
            else
            begin
                src_valid[j] = valid_reg[j-1];
                src_bcd[j]   = bcd_reg[j-1];
                src_rest[j]  = rest_reg[j-1];
            end
            bcd_next[j]  = pdd_pkg::dd_step8(src_bcd[j], src_rest[j][SAMPLE_W-1 -: BYTE_W]);
            rest_next[j] = src_rest[j] << BYTE_W;
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < STAGE_N; j++)
            begin
                valid_reg[j] <= 1'b0;
            end
        end
        else
        begin
            for (int j = 0; j < STAGE_N; j++)
            begin
                if (stage_ready[j])
                begin
                    valid_reg[j] <= src_valid[j];
                end
            end
        end
    end

    // stage data
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < STAGE_N; j++)
        begin
            if (stage_ready[j] && src_valid[j])
            begin
                bcd_reg[j]  <= bcd_next[j];
                rest_reg[j] <= rest_next[j];
            end
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[STAGE_N-1];
    assign out_bcd   = bcd_reg[STAGE_N-1];

`ifndef SYNTHESIS
    // finished word holds only decimal digits
    a_bcd_digits: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[STAGE_N-1] |-> pdd_pkg::bcd_ok(bcd_reg[STAGE_N-1]))
        else $error("bcd pipe produced a non-decimal nibble");

    // all value bits consumed by the last stage
    a_bits_used: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[STAGE_N-1] |-> (rest_reg[STAGE_N-1] == '0))
        else $error("bcd pipe left value bits unconsumed");
`endif

endmodule

[hw/rtl/pdd_digit_ser.sv]
// digit serializer: one display write per cycle while the receiver is ready, from a bcd word, msd first
module pdd_digit_ser
#(
    parameter int DIGIT_COUNT = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pdd_pkg::bcd_t      in_bcd,
    output logic               out_valid,
    input  logic               out_ready,
    output pdd_pkg::out_item_t out_item
);

    localparam int DIGIT_N = (DIGIT_COUNT < 1) ? 1 :
                             ((DIGIT_COUNT > pdd_pkg::NIB_N) ? pdd_pkg::NIB_N : DIGIT_COUNT);
    localparam int POS_W   = pdd_pkg::POS_W;
    localparam int NIB_W   = pdd_pkg::NIB_W;
    localparam int IDX_W   = $clog2(pdd_pkg::NIB_N);
    localparam logic [POS_W-1:0] POS_FIRST = POS_W'(DIGIT_N);
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(1);

    pdd_pkg::bcd_t      bcd_reg;
    logic [POS_W-1:0]   pos_reg;
    logic               busy_reg;
    logic               out_valid_reg;
    pdd_pkg::out_item_t out_item_reg;

    logic               out_free;
    logic               emit;
    logic               load;
    logic [IDX_W-1:0]   nib_idx;
    pdd_pkg::out_item_t out_item_next;

    // handshake and digit select
    assign out_free = !out_valid_reg || out_ready;
    assign emit     = busy_reg && out_free;
    assign in_ready = !busy_reg || (emit && (pos_reg == POS_LAST));
    assign load     = in_valid && in_ready;
    assign nib_idx  = IDX_W'(pos_reg - POS_LAST);

    always_comb
    begin
        out_item_next.digit_position = pos_reg;
        out_item_next.digit_value    = bcd_reg[nib_idx*NIB_W +: NIB_W];
        out_item_next.last_digit     = (pos_reg == POS_LAST);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pos_reg       <= POS_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
                pos_reg  <= POS_FIRST;
            end
            else if (emit)
            begin
                busy_reg <= (pos_reg != POS_LAST);
                pos_reg  <= pos_reg - POS_LAST;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bcd_reg <= in_bcd;
        end
        if (emit)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTHESIS
    // position stays within the display range while a word is being sent
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pos_reg >= POS_LAST && pos_reg <= POS_FIRST))
        else $error("digit position out of range");

    // a taken write that is not the last is followed at once by the next one
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ready && !out_item_reg.last_digit) |=> out_valid_reg)
        else $error("gap inside a digit run");

    // a new word is taken only when the previous run is ending
    a_load_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (load && busy_reg) |-> (emit && pos_reg == POS_LAST))
        else $error("bcd word loaded over a running run");
`endif

endmodule

[hw/rtl/pressure_to_decimal_digits.sv]
// top level: pressure sample to decimal display writes
//
// Takes a 24-bit two's complement pressure sample (three bytes, msb first),
// takes its magnitude, divides by 2^SCALE_SHIFT with truncation and sends
// DIGIT_COUNT display writes, position DIGIT_COUNT down to 1, the last one
// flagged. Fewer than eight digits shows the value modulo 10^DIGIT_COUNT.
// Path: magnitude/scale register, three double-dabble stages (one input
// byte each), then a serializer with an output register. Samples are
// accepted back to back into the pipeline; sustained throughput is set by
// the serializer, which sends one write per cycle while the receiver is
// ready and takes the next word only as the last write of a word goes out.
module pressure_to_decimal_digits
#(
    parameter int SCALE_SHIFT = 7,
    parameter int DIGIT_COUNT = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pdd_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output pdd_pkg::out_item_t out_item
);

    localparam int SHIFT_N = SCALE_SHIFT & 31;

    pdd_pkg::sample_t raw;
    pdd_pkg::sample_t mag;
    pdd_pkg::sample_t mag_reg;
    logic             mag_valid_reg;
    logic             pipe_ready;
    logic             bcd_valid;
    logic             ser_ready;
    pdd_pkg::bcd_t    bcd_word;

    // magnitude and scale
    assign raw      = {in_item.sample_high, in_item.sample_mid, in_item.sample_low};
    assign mag      = raw[pdd_pkg::SAMPLE_W-1] ? (~raw + pdd_pkg::SAMPLE_W'(1)) : raw;
    assign in_ready = !mag_valid_reg || pipe_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            mag_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            mag_reg <= mag >> SHIFT_N;
        end
    end

    // binary to bcd
    pdd_bcd_pipe u_bcd_pipe
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mag_valid_reg),
        .in_ready  (pipe_ready),
        .in_value  (mag_reg),
        .out_valid (bcd_valid),
        .out_ready (ser_ready),
        .out_bcd   (bcd_word)
    );

    // display writes
    pdd_digit_ser #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_digit_ser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (bcd_valid),
        .in_ready  (ser_ready),
        .in_bcd    (bcd_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

`ifndef SYNTHESIS
    // a taken sample always lands in the magnitude register
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> mag_valid_reg)
        else $error("accepted sample lost at magnitude stage");
`endif

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// testbench for the pressure sample to decimal digit block
module tb;

    localparam int SCALE_SHIFT      = 7;
    localparam int DIGIT_COUNT      = 8;
    localparam int SHOWN_DIGITS     = (DIGIT_COUNT < 1) ? 1 :
                                      ((DIGIT_COUNT > 8) ? 8 : DIGIT_COUNT);
    localparam int N_DIRECTED       = 16;
    localparam int RANDOM_PER_PHASE = 96;
    localparam int HOLD_CYCLES      = 300;
    localparam int DRAIN_CYCLES     = 50;
    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int REPORT_LIMIT     = 10;

    // one row of the directed table: raw sample and, where typed, its bcd digits
    typedef struct {
        logic [pdd_pkg::SAMPLE_W-1:0] raw;
        bit                           typed;
        pdd_pkg::bcd_t                digits;
    } sample_row_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    pdd_pkg::in_item_t  in_item   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    pdd_pkg::out_item_t out_item;

    // digits of samples on offer, and display writes still to come
    pdd_pkg::bcd_t      offered_digits[$];
    pdd_pkg::out_item_t pending_writes[$];
    pdd_pkg::out_item_t want;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;
    int mismatch_count = 0;

    sample_row_t directed_rows [N_DIRECTED];

    pressure_to_decimal_digits #(
        .SCALE_SHIFT (SCALE_SHIFT),
        .DIGIT_COUNT (DIGIT_COUNT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always #2 clk = ~clk;

    // magnitude of the sample, scaled down and split into decimal digits
    function automatic pdd_pkg::bcd_t scaled_digits(input pdd_pkg::in_item_t s);
        logic [pdd_pkg::SAMPLE_W-1:0] raw;
        logic [pdd_pkg::SAMPLE_W-1:0] mag;
        int unsigned                  quot;
        pdd_pkg::bcd_t                b;
        raw  = {s.sample_high, s.sample_mid, s.sample_low};
        mag  = raw[pdd_pkg::SAMPLE_W-1] ? (~raw + 1'b1) : raw;
        quot = 32'(mag) >> (SCALE_SHIFT & 31);
        b    = '0;
        for (int p = 0; p < pdd_pkg::NIB_N; p++)
        begin
            b[p*pdd_pkg::NIB_W +: pdd_pkg::NIB_W] = pdd_pkg::NIB_W'(quot % 10);
            quot = quot / 10;
        end
        return b;
    endfunction

    // display writes for one sample, most significant position first
    task automatic push_writes(input pdd_pkg::bcd_t b);
        pdd_pkg::out_item_t w;
        for (int pos = SHOWN_DIGITS; pos >= 1; pos--)
        begin
            w.digit_position = pdd_pkg::POS_W'(pos);
            w.digit_value    = b[(pos-1)*pdd_pkg::NIB_W +: pdd_pkg::NIB_W];
            w.last_digit     = (pos == 1);
            pending_writes.push_back(w);
        end
    endtask

    // random sample, weighted toward small magnitudes and the extremes
    function automatic pdd_pkg::in_item_t random_sample();
        logic [pdd_pkg::SAMPLE_W-1:0] raw;
        case ($urandom_range(3))
            0: raw = pdd_pkg::SAMPLE_W'($urandom);
            1: raw = pdd_pkg::SAMPLE_W'($urandom_range(0, 4095));
            2: raw = 24'h000000 - pdd_pkg::SAMPLE_W'($urandom_range(1, 4096));
            default:
            begin
                if ($urandom_range(1))
                    raw = 24'h7FFFFF - pdd_pkg::SAMPLE_W'($urandom_range(0, 1023));
                else
                    raw = 24'h800000 + pdd_pkg::SAMPLE_W'($urandom_range(0, 1023));
            end
        endcase
        return raw;
    endfunction

    // offer one sample until taken, then idle the input at random
    task automatic offer_sample(input pdd_pkg::in_item_t s, input pdd_pkg::bcd_t digits);
        offered_digits.push_back(digits);
        in_item  <= s;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
    endtask

    // receiver: long hold-off on request, otherwise random stalls
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // take accepted samples, check every accepted display write
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                push_writes(offered_digits.pop_front());
            if (out_valid && out_ready)
            begin
                if (pending_writes.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected write: pos %0d digit %0d last %0b",
                                 out_item.digit_position, out_item.digit_value,
                                 out_item.last_digit);
                end
                else
                begin
                    want = pending_writes.pop_front();
                    if (out_item.digit_position !== want.digit_position ||
                        out_item.digit_value !== want.digit_value ||
                        out_item.last_digit !== want.last_digit)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display({"write mismatch: expected pos %0d digit %0d last %0b,",
                                      " got pos %0d digit %0d last %0b"},
                                     want.digit_position, want.digit_value,
                                     want.last_digit, out_item.digit_position,
                                     out_item.digit_value, out_item.last_digit);
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
        end
    end

    // watchdog on cycles with no item moving on either side
    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        pdd_pkg::in_item_t s;

        // extremes, both signs around zero, the most negative sample, bit patterns
        directed_rows = '{
            '{24'h000000, 1'b1, 32'h0000_0000},
            '{24'h7FFFFF, 1'b1, 32'h0006_5535},
            '{24'h800000, 1'b1, 32'h0006_5536},
            '{24'hFFFFFF, 1'b1, 32'h0000_0000},
            '{24'h000080, 1'b1, 32'h0000_0001},
            '{24'h00007F, 1'b1, 32'h0000_0000},
            '{24'hFFFF80, 1'b1, 32'h0000_0001},
            '{24'h800001, 1'b1, 32'h0006_5535},
            '{24'h000100, 1'b1, 32'h0000_0002},
            '{24'hFF0000, 1'b0, 32'h0},
            '{24'h00FF00, 1'b0, 32'h0},
            '{24'h0000FF, 1'b0, 32'h0},
            '{24'hAA55AA, 1'b0, 32'h0},
            '{24'h55AA55, 1'b0, 32'h0},
            '{24'h138780, 1'b0, 32'h0},
            '{24'hEDCBAA, 1'b0, 32'h0}
        };

        // reset
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table, no idling
        foreach (directed_rows[i])
        begin
            s = directed_rows[i].raw;
            offer_sample(s, directed_rows[i].typed ? directed_rows[i].digits
                                                   : scaled_digits(s));
        end

        // random phases with different idling on each side
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            // long output hold-off while samples keep coming, so the input backs up
            if (phase == 0)
                hold_request = HOLD_CYCLES;
            repeat (RANDOM_PER_PHASE)
            begin
                s = random_sample();
                offer_sample(s, scaled_digits(s));
            end
            // sender pauses until every write of the phase is out
            in_valid <= 1'b0;
            while (pending_writes.size() != 0)
                @(posedge clk);
            @(negedge clk);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_writes.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/pdd_pkg.sv
hw/rtl/pdd_bcd_pipe.sv
hw/rtl/pdd_digit_ser.sv
hw/rtl/pressure_to_decimal_digits.sv
bench/tb.sv
